[design/hstd_pkg.sv]
// Shared types and constants for the serialized-tree Huffman decoder.
// No dependencies.
`default_nettype none
package hstd_pkg;
  localparam int unsigned TableEntriesDef = 2048;
  localparam int unsigned StackDepthDef   = 2048;
  localparam int unsigned LeafLimit       = 256;
  localparam int unsigned LenW            = 24;

  localparam logic [1:0] KIND_SYMBOL   = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;
  localparam logic [1:0] KIND_EARLY    = 2'd3;

  // Item handed from the front queue to the bit engine.
  typedef struct packed {
    logic       eoi;
    logic [7:0] data;
  } hstd_item_t;
endpackage
`default_nettype wire

[design/hstd_queue.sv]
// Short item queue between input front end and bit engine.
// Uses hstd_pkg.
`default_nettype none
module hstd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hstd_pkg::hstd_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hstd_pkg::hstd_item_t    out_item_o
);
  import hstd_pkg::*;

  hstd_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("queue pop");
  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue push");
`endif
endmodule
`default_nettype wire

[design/hstd_engine.sv]
// Bit engine: rebuilds the tree and walks it, one bit per step.
// Uses hstd_pkg; child tables and build stack are local memories.
`default_nettype none
module hstd_engine #(
  parameter int unsigned TABLE_ENTRIES = hstd_pkg::TableEntriesDef,
  parameter int unsigned STACK_DEPTH   = hstd_pkg::StackDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [23:0]          out_len_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire hstd_pkg::hstd_item_t in_item_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output logic [1:0]                res_kind_o,
  output logic [7:0]                res_symbol_o,
  output logic [23:0]               res_repeat_o,
  output logic                      res_last_o
);
  import hstd_pkg::*;

  localparam int unsigned NW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned VW = (NW > 8) ? NW : 9;
  // Stack pointer must hold STACK_DEPTH itself.
  localparam int unsigned PW = SW + 1;
  localparam int unsigned CW = (VW > PW) ? VW : PW;

  typedef enum logic [3:0] {
    S_IDLE, S_BIT, S_SREAD, S_ATTACH, S_PUSH, S_WREAD, S_WSTEP, S_EMIT, S_FLUSH, S_DONE
  } state_e;
  typedef enum logic [1:0] {PH_BUILD, PH_DECODE, PH_DONE} phase_e;

  logic [NW-1:0] left_mem  [TABLE_ENTRIES];
  logic [NW-1:0] right_mem [TABLE_ENTRIES];
  logic [NW:0]   stack_mem [STACK_DEPTH];

  state_e      st_q;
  phase_e      ph_q;
  logic [7:0]  byte_q;
  logic [2:0]  bit_q;
  logic [PW-1:0] sp_q;
  logic [CW:0] nfree_q;
  logic [7:0]  lit_q;
  logic [3:0]  lbits_q;
  logic [VW-1:0] root_q, walk_q, attv_q;
  logic [23:0] prod_q;
  logic [NW:0] top_q;
  logic [NW-1:0] lrd_q, rrd_q;
  logic        wbit_q;
  // Pending results: up to two (symbol then finished).
  logic [1:0]  p_kind_q [2];
  logic [7:0]  p_sym_q  [2];
  logic [23:0] p_rep_q  [2];
  logic [1:0]  p_cnt_q;
  logic        p_idx_q;
  logic        p_end_q;   // item finishes after emitting
  logic        p_done_q;  // phase goes to done after emitting
  // Staged result: held back until the next one or the end of the item sets last.
  logic        stg_v_q;
  logic [1:0]  stg_kind_q;
  logic [7:0]  stg_sym_q;
  logic [23:0] stg_rep_q;
  logic [1:0]  kind_q;
  logic [7:0]  sym_q;
  logic [23:0] rep_q;
  logic        last_q, valid_q;

  logic        cur_bit;
  logic        item_over;
  logic [NW:0] node_top;
  logic        out_free, stg_move, stg_last;

  assign cur_bit   = byte_q[bit_q];
  assign item_over = (bit_q == 3'd0);
  assign node_top  = top_q;
  assign in_ready_o = (st_q == S_IDLE) || (st_q == S_DONE);
  assign res_valid_o = valid_q;
  assign res_kind_o = kind_q;
  assign res_symbol_o = sym_q;
  assign res_repeat_o = rep_q;
  assign res_last_o = last_q;

  assign out_free = !valid_q || res_ready_i;
  assign stg_move = stg_v_q && out_free && ((st_q == S_EMIT) || (st_q == S_FLUSH));
  assign stg_last = (st_q == S_FLUSH);

  // Memory writes.
  logic          lw_en, rw_en, sw_en;
  logic [NW-1:0] tw_addr, tw_data;
  logic [SW-1:0] sw_addr;
  logic [NW:0]   sw_data;
  logic [SW-1:0] sr_addr;
  logic [NW-1:0] wr_addr;

  always_ff @(posedge clk_i) begin
    if (lw_en) left_mem[tw_addr] <= tw_data;
    if (rw_en) right_mem[tw_addr] <= tw_data;
    if (sw_en) stack_mem[sw_addr] <= sw_data;
    top_q <= stack_mem[sr_addr];
    lrd_q <= left_mem[wr_addr];
    rrd_q <= right_mem[wr_addr];
  end

  assign sr_addr = SW'(sp_q - PW'(1));
  assign wr_addr = walk_q[NW-1:0];

  // Attach logic for S_ATTACH, combinational on registered stack top.
  // An internal node is pushed in the following cycle, in S_PUSH.
  logic [PW-1:0] sp_a;
  logic          att_res_cmp, att_ovf;
  always_comb begin
    lw_en = 1'b0; rw_en = 1'b0; sw_en = 1'b0;
    tw_addr = node_top[NW:1]; tw_data = attv_q[NW-1:0];
    sw_addr = sr_addr; sw_data = {node_top[NW:1], 1'b1};
    sp_a = sp_q;
    att_ovf = 1'b0; att_res_cmp = 1'b0;
    if (st_q == S_ATTACH) begin
      if (sp_q != '0) begin
        if (node_top[0] == 1'b0) begin
          lw_en = 1'b1; sw_en = 1'b1;
        end else begin
          rw_en = 1'b1; sp_a = sp_q - PW'(1);
        end
      end
      if (attv_q >= VW'(LeafLimit)) begin
        att_ovf = (sp_a >= PW'(STACK_DEPTH));
      end else begin
        att_res_cmp = (sp_a == '0);
      end
    end else if (st_q == S_PUSH) begin
      sw_en = 1'b1; sw_addr = sp_q[SW-1:0];
      sw_data = {attv_q[NW-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ph_q <= PH_BUILD; sp_q <= '0;
      nfree_q <= (CW+1)'(LeafLimit); lit_q <= '0; lbits_q <= '0;
      root_q <= '0; walk_q <= '0; prod_q <= '0; valid_q <= 1'b0;
      p_cnt_q <= '0; p_idx_q <= 1'b0; p_end_q <= 1'b0; p_done_q <= 1'b0;
      bit_q <= '0; byte_q <= '0; attv_q <= '0; wbit_q <= 1'b0;
      stg_v_q <= 1'b0; stg_kind_q <= '0; stg_sym_q <= '0; stg_rep_q <= '0;
      kind_q <= '0; sym_q <= '0; rep_q <= '0; last_q <= 1'b0;
    end else begin
      if (stg_move) begin
        valid_q <= 1'b1;
        kind_q <= stg_kind_q; sym_q <= stg_sym_q; rep_q <= stg_rep_q;
        last_q <= stg_last;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            byte_q <= in_item_i.data; bit_q <= 3'd7;
            if (in_item_i.eoi) begin
              p_kind_q[0] <= KIND_EARLY; p_sym_q[0] <= '0; p_rep_q[0] <= '0;
              p_cnt_q <= 2'd1; p_idx_q <= 1'b0; p_end_q <= 1'b1; p_done_q <= 1'b1;
              st_q <= S_EMIT;
            end else begin
              st_q <= (ph_q == PH_DECODE) ? S_WREAD : S_BIT;
            end
          end
        end
        S_BIT: begin
          if (lbits_q != '0) begin
            lit_q <= {lit_q[6:0], cur_bit};
            lbits_q <= lbits_q - 4'd1;
            if (lbits_q == 4'd1) begin
              attv_q <= VW'({lit_q[6:0], cur_bit}); st_q <= S_SREAD;
            end else if (item_over) st_q <= S_IDLE;
            else bit_q <= bit_q - 3'd1;
          end else if (cur_bit) begin
            if (nfree_q >= (CW+1)'(TABLE_ENTRIES)) begin
              p_kind_q[0] <= KIND_OVERFLOW; p_sym_q[0] <= '0; p_rep_q[0] <= '0;
              p_cnt_q <= 2'd1; p_idx_q <= 1'b0; p_end_q <= 1'b1; p_done_q <= 1'b1;
              st_q <= S_EMIT;
            end else begin
              attv_q <= VW'(nfree_q); nfree_q <= nfree_q + 1'b1; st_q <= S_SREAD;
            end
          end else begin
            lbits_q <= 4'd8; lit_q <= '0;
            if (item_over) st_q <= S_IDLE; else bit_q <= bit_q - 3'd1;
          end
        end
        S_SREAD: st_q <= S_ATTACH;
        S_ATTACH: begin
          sp_q <= sp_a;
          if (sp_q == '0) root_q <= attv_q;
          if (att_ovf) begin
            p_kind_q[0] <= KIND_OVERFLOW; p_sym_q[0] <= '0; p_rep_q[0] <= '0;
            p_cnt_q <= 2'd1; p_idx_q <= 1'b0; p_end_q <= 1'b1; p_done_q <= 1'b1;
            st_q <= S_EMIT;
          end else if (attv_q >= VW'(LeafLimit)) begin
            st_q <= S_PUSH;
          end else if (att_res_cmp) begin
            // Tree complete.
            logic [VW-1:0] rt;
            rt = (sp_q == '0) ? attv_q : root_q;
            walk_q <= rt;
            if (rt < VW'(LeafLimit)) begin
              prod_q <= out_len_i;
              p_kind_q[0] <= KIND_SYMBOL; p_sym_q[0] <= rt[7:0];
              p_rep_q[0] <= out_len_i;
              p_kind_q[1] <= KIND_FINISHED; p_sym_q[1] <= '0; p_rep_q[1] <= '0;
              p_cnt_q <= (out_len_i != '0) ? 2'd2 : 2'd1;
              p_idx_q <= (out_len_i != '0) ? 1'b0 : 1'b1;
              p_end_q <= 1'b1; p_done_q <= 1'b1; st_q <= S_EMIT;
            end else if (prod_q >= out_len_i) begin
              p_kind_q[0] <= KIND_FINISHED; p_sym_q[0] <= '0; p_rep_q[0] <= '0;
              p_cnt_q <= 2'd1; p_idx_q <= 1'b0; p_end_q <= 1'b1; p_done_q <= 1'b1;
              st_q <= S_EMIT;
            end else begin
              ph_q <= PH_DECODE;
              if (item_over) st_q <= S_IDLE;
              else begin bit_q <= bit_q - 3'd1; st_q <= S_WREAD; end
            end
          end else if (item_over) st_q <= S_IDLE;
          else begin bit_q <= bit_q - 3'd1; st_q <= S_BIT; end
        end
        S_PUSH: begin
          sp_q <= sp_q + PW'(1);
          if (item_over) st_q <= S_IDLE;
          else begin bit_q <= bit_q - 3'd1; st_q <= S_BIT; end
        end
        S_WREAD: begin wbit_q <= cur_bit; st_q <= S_WSTEP; end
        S_WSTEP: begin
          logic [VW-1:0] nx;
          nx = VW'(wbit_q ? rrd_q : lrd_q);
          if (nx < VW'(LeafLimit)) begin
            walk_q <= root_q;
            prod_q <= prod_q + 24'd1;
            p_kind_q[0] <= KIND_SYMBOL; p_sym_q[0] <= nx[7:0]; p_rep_q[0] <= 24'd1;
            p_kind_q[1] <= KIND_FINISHED; p_sym_q[1] <= '0; p_rep_q[1] <= '0;
            p_idx_q <= 1'b0;
            if (prod_q + 24'd1 >= out_len_i) begin
              p_cnt_q <= 2'd2; p_end_q <= 1'b1; p_done_q <= 1'b1;
            end else begin
              p_cnt_q <= 2'd1; p_end_q <= item_over; p_done_q <= 1'b0;
            end
            st_q <= S_EMIT;
          end else begin
            walk_q <= nx;
            if (item_over) st_q <= S_FLUSH;
            else begin bit_q <= bit_q - 3'd1; st_q <= S_WREAD; end
          end
        end
        S_EMIT: begin
          if (!stg_v_q || out_free) begin
            stg_v_q <= 1'b1;
            stg_kind_q <= p_kind_q[p_idx_q]; stg_sym_q <= p_sym_q[p_idx_q];
            stg_rep_q <= p_rep_q[p_idx_q];
            p_cnt_q <= p_cnt_q - 2'd1; p_idx_q <= 1'b1;
            if (p_cnt_q == 2'd1) begin
              if (p_done_q) begin ph_q <= PH_DONE; st_q <= S_FLUSH; end
              else if (p_end_q) st_q <= S_FLUSH;
              else begin bit_q <= bit_q - 3'd1; st_q <= S_WREAD; end
            end
          end
        end
        S_FLUSH: begin
          // Release the staged result as the last one of this item.
          if (!stg_v_q || out_free) begin
            stg_v_q <= 1'b0;
            st_q <= (ph_q == PH_DONE) ? S_DONE : S_IDLE;
          end
        end
        S_DONE: ;
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DONE |=> st_q == S_DONE) else $error("left done state");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_ready_i) |=> valid_q && $stable(kind_q) && $stable(sym_q))
    else $error("result changed while stalled");
  a_walk_internal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_WSTEP |-> walk_q >= VW'(LeafLimit)) else $error("walk at leaf");
`endif
endmodule
`default_nettype wire

[design/huffman_serialized_tree_decoder_unit.sv]
// Top level: input queue feeding the tree build / walk engine; uses hstd_pkg, hstd_queue.
// Steps: the engine accepts a byte in S_IDLE, then tree build takes each bit in S_BIT;
// a bit ending a node adds stack-top read and attach, and a push if it is internal;
// in decode a child read and step per bit, an emit per result, a release of the last one.
// Items first pass the queue; results pass a staging and an output register; stalls add.
// Reset (async, low) clears control state and restarts tree build; tables are not cleared.
`default_nettype none
module huffman_serialized_tree_decoder_unit #(
  parameter int unsigned TABLE_ENTRIES = hstd_pkg::TableEntriesDef,
  parameter int unsigned STACK_DEPTH   = hstd_pkg::StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] compressed_byte
  input  wire logic        s_axis_tuser,  // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [7:0] symbol, [31:8] repeat_res
  output logic [1:0]       m_axis_tuser,  // [1:0] kind
  output logic             m_axis_tlast   // last
);
  import hstd_pkg::*;

  logic [23:0] len_q;
  hstd_item_t  qin, qout;
  logic        q_valid, q_ready;
  logic [1:0]  kind;
  logic [7:0]  sym;
  logic [23:0] rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) len_q <= '0;
    else if (cfg_we_i) len_q <= cfg_wdata_i;
  end

  assign qin.eoi  = s_axis_tuser;
  assign qin.data = s_axis_tdata;

  hstd_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(qin),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(qout)
  );

  hstd_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .STACK_DEPTH(STACK_DEPTH)) u_engine (
    .clk_i, .rst_ni, .out_len_i(len_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(qout),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_kind_o(kind), .res_symbol_o(sym), .res_repeat_o(rep),
    .res_last_o(m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {rep, sym};
endmodule
`default_nettype wire
